>>> rtl/trwq_pkg.sv
// ----------------------------------------------------------------------------
// trwq_pkg
// Shared types and codes of the timed register write queue.
// ----------------------------------------------------------------------------
package trwq_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2
    } trwq_op_t;

    // Status codes of a result item.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_TOO_FAR = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_DONE    = 2'd3
    } trwq_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } trwq_state_t;

    // Configuration port: register index sits above the byte offset.
    localparam int          PADDR_W              = 3;
    localparam logic        REG_IDX_MAX_LATENCY  = 1'b0;
    localparam logic [30:0] MAX_LATENCY_RESET    = 31'd1000000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_us;
        logic [31:0] due_time_us;
        logic [15:0] reg_address;
        logic [7:0]  reg_data;
    } trwq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
    } trwq_rsp_t;

    // One slot of the event store.
    typedef struct packed {
        logic [31:0] due_time_us;
        logic [15:0] reg_address;
        logic [7:0]  reg_data;
    } trwq_entry_t;

    // Result that carries no register write.
    function automatic trwq_rsp_t plain_result(input trwq_status_t st);
        trwq_rsp_t r;
        r.status        = st;
        r.write_valid   = 1'b0;
        r.write_address = 16'd0;
        r.write_data    = 8'd0;
        r.last          = 1'b1;
        return r;
    endfunction

    // Result that issues a drained register write.
    function automatic trwq_rsp_t write_result(input logic [15:0] addr,
                                               input logic [7:0]  data,
                                               input logic        is_last);
        trwq_rsp_t r;
        r.status        = STAT_DONE;
        r.write_valid   = 1'b1;
        r.write_address = addr;
        r.write_data    = data;
        r.last          = is_last;
        return r;
    endfunction

endpackage

>>> rtl/trwq_if.sv
// ----------------------------------------------------------------------------
// trwq_if
// Valid/ready channels carrying request and result items of the queue.
// ----------------------------------------------------------------------------
interface trwq_req_if;
    import trwq_pkg::*;

    logic      valid;
    logic      ready;
    trwq_req_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface trwq_rsp_if;
    import trwq_pkg::*;

    logic      valid;
    logic      ready;
    trwq_rsp_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/trwq_cfg.sv
// ----------------------------------------------------------------------------
// trwq_cfg
// APB register block holding the latency limit.
// ----------------------------------------------------------------------------
module trwq_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trwq_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [30:0]                     max_latency_us
);
    import trwq_pkg::*;

    logic [30:0] max_latency_reg;
    logic        hit;

    assign hit    = paddr[PADDR_W-1] == REG_IDX_MAX_LATENCY;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_latency_reg <= MAX_LATENCY_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            max_latency_reg <= pwdata[30:0];
        end
    end

    assign prdata         = hit ? {1'b0, max_latency_reg} : 32'd0;
    assign max_latency_us = max_latency_reg;

endmodule

>>> rtl/trwq_store.sv
// ----------------------------------------------------------------------------
// trwq_store
// Event ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module trwq_store #(
    parameter int QUEUE_DEPTH = 16384,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  trwq_pkg::trwq_entry_t wr_entry,
    input  logic [AW-1:0]         rd_addr,
    output trwq_pkg::trwq_entry_t rd_entry
);
    import trwq_pkg::*;

    trwq_entry_t mem [QUEUE_DEPTH];
    trwq_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

>>> rtl/trwq_ctrl.sv
// ----------------------------------------------------------------------------
// trwq_ctrl
// Ring pointers, push checks, tick drain sequencer and result register.
// ----------------------------------------------------------------------------
module trwq_ctrl #(
    parameter int QUEUE_DEPTH   = 16384,
    parameter int DRAIN_MAX     = 64,
    parameter int DUE_WINDOW_US = 1000,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    trwq_req_if.sink              req,
    trwq_rsp_if.source            rsp,
    input  logic [30:0]           max_latency_us,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output trwq_pkg::trwq_entry_t wr_entry,
    output logic [AW-1:0]         rd_addr,
    input  trwq_pkg::trwq_entry_t rd_entry
);
    import trwq_pkg::*;

    localparam int                 CW        = $clog2(DRAIN_MAX + 1);
    localparam logic [AW-1:0]      LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic signed [31:0] WINDOW    = 32'(DUE_WINDOW_US);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    trwq_state_t state_reg, state_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [15:0]   pend_addr_reg, pend_addr_next;
    logic [7:0]    pend_data_reg, pend_data_next;
    logic [31:0]   now_reg, now_next;
    logic          out_valid_reg, out_valid_next;
    trwq_rsp_t     out_item_reg, out_item_next;

    logic        out_free;
    logic        req_fire;
    logic [31:0] push_lead;
    logic        too_far;
    logic        full;
    logic        empty;
    logic [31:0] head_lead;
    logic        head_due;
    logic        pop;
    logic        finish;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    assign push_lead = req.item.due_time_us - req.item.now_us;
    assign too_far   = $signed(push_lead) > $signed({1'b0, max_latency_us});
    assign full      = ring_next(wp_reg) == rp_reg;
    assign empty     = rp_reg == wp_reg;

    // The store output always holds the entry at the read pointer while draining.
    assign head_lead = rd_entry.due_time_us - now_reg;
    assign head_due  = $signed(head_lead) < WINDOW;

    assign pop    = (state_reg == ST_DRAIN) && out_free && !empty && head_due
                    && (cnt_reg < CW'(DRAIN_MAX));
    assign finish = (state_reg == ST_DRAIN) && out_free && !pop;

    assign rd_addr  = pop ? ring_next(rp_reg) : rp_reg;
    assign wr_addr  = wp_reg;
    assign wr_entry = '{due_time_us: req.item.due_time_us,
                        reg_address: req.item.reg_address,
                        reg_data:    req.item.reg_data};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.item.operation == OP_TICK)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_item_next   = out_item_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.item.operation)
                        OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (too_far)
                            begin
                                out_item_next = plain_result(STAT_TOO_FAR);
                            end
                            else if (full)
                            begin
                                out_item_next = plain_result(STAT_FULL);
                            end
                            else
                            begin
                                out_item_next = plain_result(STAT_OK);
                                wr_en         = 1'b1;
                                wp_next       = ring_next(wp_reg);
                            end
                        end
                        OP_TICK:
                        begin
                            now_next        = req.item.now_us;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                        end
                        OP_FLUSH:
                        begin
                            rp_next        = '0;
                            wp_next        = '0;
                            out_valid_next = 1'b1;
                            out_item_next  = plain_result(STAT_DONE);
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = plain_result(STAT_DONE);
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                // A drained write is held back in the pending register until it is known
                // whether another one follows, so that it can carry last.
                if (pop)
                begin
                    rp_next         = ring_next(rp_reg);
                    cnt_next        = cnt_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_entry.reg_address;
                    pend_data_next  = rd_entry.reg_data;
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = write_result(pend_addr_reg, pend_data_reg, 1'b0);
                    end
                end
                else if (finish)
                begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    out_item_next   = pend_valid_reg
                                      ? write_result(pend_addr_reg, pend_data_reg, 1'b1)
                                      : plain_result(STAT_DONE);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        now_reg       <= now_next;
        out_item_reg  <= out_item_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    a_write_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.write_valid |-> out_item_reg.status == STAT_DONE)
        else $error("issued write without tick status");

    a_pending_only_draining: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg == ST_DRAIN && cnt_reg != '0)
        else $error("held write outside a drain");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DRAIN_MAX))
        else $error("drain count beyond bound");

    a_push_advances: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.item.operation == OP_PUSH && !too_far && !full
        |=> wp_reg == ring_next($past(wp_reg)) && out_valid_reg)
        else $error("accepted push did not advance write pointer");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rp_reg != wp_reg && state_reg == ST_DRAIN)
        else $error("pop from empty ring");

endmodule

>>> rtl/timed_register_write_queue.sv
// ----------------------------------------------------------------------------
// timed_register_write_queue
// Ring queue of timestamped register writes with push, tick drain and flush.
// ----------------------------------------------------------------------------
// A push or a flush gives one result. A new item is taken every cycle as
// long as no tick is draining and the result side takes each result. A
// tick reads the head slot from the event store in its accept cycle. It
// then drains the due writes one by one, up to DRAIN_MAX of them, and
// closes with a final result. The result side can stall the drain by
// holding back a result. The single read port of the store sets the pace
// of the drain. The store has no reset and needs no clearing pass, because
// only slots written by a push are read.
module timed_register_write_queue #(
    parameter int QUEUE_DEPTH   = 16384,
    parameter int DRAIN_MAX     = 64,
    parameter int DUE_WINDOW_US = 1000
) (
    input  logic                         clk,
    input  logic                         rst_n,
    trwq_req_if.sink                     req,
    trwq_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trwq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import trwq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [30:0]   max_latency_us;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    trwq_entry_t   wr_entry;
    logic [AW-1:0] rd_addr;
    trwq_entry_t   rd_entry;

    trwq_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_latency_us (max_latency_us)
    );

    trwq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    trwq_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DRAIN_MAX     (DRAIN_MAX),
        .DUE_WINDOW_US (DUE_WINDOW_US)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .max_latency_us (max_latency_us),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_entry       (wr_entry),
        .rd_addr        (rd_addr),
        .rd_entry       (rd_entry)
    );

endmodule

>>> sim/trwq_checker.sv
// ----------------------------------------------------------------------------
// trwq_checker
// Watches the request, result and register channels of the timed register
// write queue. It keeps its own copy of the queued writes and of the latency
// limit, works out the results of every accepted request, and compares each
// result transfer field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module trwq_checker #(
    parameter int QUEUE_DEPTH   = 16384,
    parameter int DRAIN_MAX     = 64,
    parameter int DUE_WINDOW_US = 1000
) (
    input  logic                         clk,
    input  logic                         rst_n,
    trwq_req_if                          req,
    trwq_rsp_if                          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trwq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           mismatch_count,
    output int                           pending_count
);
    import trwq_pkg::*;

    trwq_entry_t queued_writes[$];
    trwq_rsp_t   awaited_results[$];
    logic [30:0] latency_limit;
    int          errors;
    trwq_rsp_t   want;
    trwq_rsp_t   seen;

    function automatic trwq_rsp_t quiet_result(input trwq_status_t st);
        trwq_rsp_t r;
        r.status        = st;
        r.write_valid   = 1'b0;
        r.write_address = 16'd0;
        r.write_data    = 8'd0;
        r.last          = 1'b1;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // Leads are signed 32-bit differences, so overdue events count as due
    // and due times behind the current time always pass the latency check.
    task automatic forecast_results(input trwq_req_t it);
        int        lead;
        int        issued;
        trwq_rsp_t r;
        case (it.operation)
            OP_PUSH:
            begin
                lead = int'(it.due_time_us - it.now_us);
                if (longint'(lead) > longint'(latency_limit))
                    awaited_results.push_back(quiet_result(STAT_TOO_FAR));
                else if (queued_writes.size() == QUEUE_DEPTH - 1)
                    awaited_results.push_back(quiet_result(STAT_FULL));
                else
                begin
                    queued_writes.push_back({it.due_time_us, it.reg_address, it.reg_data});
                    awaited_results.push_back(quiet_result(STAT_OK));
                end
            end
            OP_TICK:
            begin
                issued = 0;
                while (issued < DRAIN_MAX && queued_writes.size() > 0 &&
                       int'(queued_writes[0].due_time_us - it.now_us) < DUE_WINDOW_US)
                begin
                    r.status        = STAT_DONE;
                    r.write_valid   = 1'b1;
                    r.write_address = queued_writes[0].reg_address;
                    r.write_data    = queued_writes[0].reg_data;
                    r.last          = 1'b0;
                    awaited_results.push_back(r);
                    void'(queued_writes.pop_front());
                    issued++;
                end
                if (issued == 0)
                    awaited_results.push_back(quiet_result(STAT_DONE));
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
            OP_FLUSH:
            begin
                queued_writes.delete();
                awaited_results.push_back(quiet_result(STAT_DONE));
            end
            default:
            begin
                awaited_results.push_back(quiet_result(STAT_DONE));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_writes.delete();
            awaited_results.delete();
            latency_limit = MAX_LATENCY_RESET;
            errors = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pready &&
                paddr[trwq_pkg::PADDR_W-1:2] == REG_IDX_MAX_LATENCY)
            begin
                if (pwrite)
                    latency_limit = pwdata[30:0];
                else if (prdata !== {1'b0, latency_limit})
                    flag_error($sformatf("register read: expected %h, got %h",
                                         {1'b0, latency_limit}, prdata));
            end

            if (req.valid && req.ready)
                forecast_results(req.item);

            if (rsp.valid && rsp.ready)
            begin
                seen = rsp.item;
                if (awaited_results.size() == 0)
                    flag_error($sformatf("result transfer with none outstanding: %p", seen));
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status ||
                        seen.write_valid !== want.write_valid ||
                        seen.write_address !== want.write_address ||
                        seen.write_data !== want.write_data ||
                        seen.last !== want.last)
                        flag_error($sformatf({"result mismatch: expected status %0d ",
                            "valid %b addr %h data %h last %b, got status %0d valid %b ",
                            "addr %h data %h last %b"},
                            want.status, want.write_valid, want.write_address,
                            want.write_data, want.last, seen.status, seen.write_valid,
                            seen.write_address, seen.write_data, seen.last));
                end
            end

            // Published with a nonblocking update so the stimulus side can
            // read them at the clock edge without a race.
            mismatch_count <= errors;
            pending_count <= awaited_results.size();
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the timed register write queue. A directed part covers the
// latency and due-window edges, time wrap, multi-write ticks, flush and the
// spare operation code. Random phases then run under several latency limits,
// the first with no gaps and the rest with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import trwq_pkg::*;

    localparam int         QUEUE_DEPTH   = 16384;
    localparam int         DRAIN_MAX     = 64;
    localparam int         DUE_WINDOW_US = 1000;
    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam int         LIMIT_CYCLES  = 1_000_000;
    localparam int         PHASE_ITEMS   = 65;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   mismatch_count;
    int                   pending_count;
    bit                   calm;
    logic [31:0]          wall_clock;
    logic [30:0]          latency_setting;

    trwq_req_if req_ch();
    trwq_rsp_if rsp_ch();

    timed_register_write_queue #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DRAIN_MAX     (DRAIN_MAX),
        .DUE_WINDOW_US (DUE_WINDOW_US)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    trwq_checker #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DRAIN_MAX     (DRAIN_MAX),
        .DUE_WINDOW_US (DUE_WINDOW_US)
    ) queue_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // Offers one item and returns at the edge where it is transferred.
    task automatic send(input trwq_req_t it);
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.item <= it;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic issue(input logic [1:0] op, input logic [31:0] now,
                         input logic [31:0] due, input logic [15:0] addr,
                         input logic [7:0] data);
        trwq_req_t it;
        it.operation   = op;
        it.now_us      = now;
        it.due_time_us = due;
        it.reg_address = addr;
        it.reg_data    = data;
        send(it);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic reg_access(input bit is_write, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {REG_IDX_MAX_LATENCY, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_latency(input logic [31:0] value);
        wait_drained();
        reg_access(1'b1, value);
        reg_access(1'b0, 32'd0);
        latency_setting = value[30:0];
    endtask

    // Mostly coherent traffic: pushes due a little ahead of a slowly moving
    // time, ticks that advance it, and now and then a jump or a wild value.
    task automatic random_request(output trwq_req_t it);
        int pick;
        int shape;
        pick = $urandom_range(0, 99);
        it.due_time_us = $urandom;
        it.reg_address = $urandom;
        it.reg_data    = $urandom;
        if ($urandom_range(0, 19) == 0)
            wall_clock = $urandom;
        else if (pick >= 55)
            wall_clock += $urandom_range(0, 400);
        it.now_us = wall_clock;
        if (pick < 55)
        begin
            it.operation = OP_PUSH;
            shape = $urandom_range(0, 9);
            if (shape < 5)
                it.due_time_us = wall_clock + $urandom_range(0, 2500) - 500;
            else if (shape < 7)
                it.due_time_us = wall_clock + {1'b0, latency_setting}
                                 + $urandom_range(0, 2) - 1;
            else if (shape == 7)
                it.due_time_us = wall_clock - $urandom;
        end
        else if (pick < 88)
            it.operation = OP_TICK;
        else if (pick < 94)
            it.operation = OP_FLUSH;
        else
            it.operation = OP_SPARE;
    endtask

    initial
    begin
        logic [31:0] settings[6];
        trwq_req_t   it;

        rst_n = 1'b0;
        calm = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        wall_clock = $urandom;
        latency_setting = MAX_LATENCY_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Limit at its reset value: edges of the lead and of the due window.
        issue(OP_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        issue(OP_PUSH, 32'd0, 32'd1000000, 16'hFFFF, 8'hFF);
        issue(OP_PUSH, 32'd0, 32'd1000001, 16'h1111, 8'h11);
        issue(OP_PUSH, 32'd0, 32'h7FFF_FFFF, 16'h2222, 8'h22);
        issue(OP_PUSH, 32'd0, 32'h8000_0000, 16'h0000, 8'h00);
        issue(OP_TICK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        issue(OP_TICK, 32'd999000, 32'd0, 16'd0, 8'd0);
        issue(OP_TICK, 32'd999001, 32'd0, 16'd0, 8'd0);
        issue(OP_TICK, 32'h8000_0000, 32'd0, 16'd0, 8'd0);
        // Due times that lie across the wrap of the time counter.
        issue(OP_PUSH, 32'hFFFF_FF00, 32'h0000_0010, 16'h1234, 8'h5A);
        issue(OP_PUSH, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'hABCD, 8'hA5);
        issue(OP_TICK, 32'hFFFF_FF00, 32'd0, 16'd0, 8'd0);
        issue(OP_PUSH, 32'd0, 32'd5000, 16'h5555, 8'hAA);
        issue(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        issue(OP_TICK, 32'd5000, 32'd0, 16'd0, 8'd0);
        issue(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);

        // A zero limit takes only due times at or behind the current time.
        set_latency(32'd0);
        issue(OP_PUSH, 32'd100, 32'd100, 16'h8001, 8'h7E);
        issue(OP_PUSH, 32'd100, 32'd101, 16'h8002, 8'h81);
        issue(OP_PUSH, 32'd100, 32'd99, 16'h8003, 8'h3C);
        issue(OP_TICK, 32'd100, 32'd0, 16'd0, 8'd0);

        // Bit 31 of the write data falls outside the 31-bit register.
        set_latency(32'hFFFF_FFFF);
        issue(OP_PUSH, 32'd0, 32'h7FFF_FFFF, 16'h4242, 8'h42);
        issue(OP_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        issue(OP_FLUSH, 32'd0, 32'd0, 16'd0, 8'd0);

        settings[0] = 32'd1000000;
        settings[1] = 32'd0;
        settings[2] = 32'hFFFF_FFFF;
        settings[3] = 32'd1000;
        settings[4] = $urandom_range(0, 5000);
        settings[5] = $urandom;
        foreach (settings[p])
        begin
            set_latency(settings[p]);
            // The first phase runs with no gaps on either channel.
            calm = (p == 0);
            repeat (PHASE_ITEMS)
            begin
                random_request(it);
                send(it);
            end
        end

        wait_drained();
        repeat (DRAIN_MAX + 16) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
